### src/csed_pkg.sv
// Package: shared types, character codes and decode helpers for the escape decoder.
`default_nettype none
package csed_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2,
    MODE_HEX    = 2'd3
  } mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_F   = 8'h46;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_NINE      = 8'h39;

  localparam logic [1:0] ESC_DIGITS = 2'd2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QLVL_W = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       summary;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    entry_t e0;
    entry_t e1;
  } push_t;

  typedef struct packed {
    logic              empty;
    logic              room;
    logic [QLVL_W-1:0] level;
  } qstat_t;

  // Returns {valid, value} for a hex digit character.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      r = {1'b1, 4'(ch - CH_ZERO)};
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
      r = {1'b1, 4'(ch - CH_UPPER_A + 8'd10)};
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
      r = {1'b1, 4'(ch - CH_LOWER_A + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] ch);
    logic [7:0] r;
    unique case (ch)
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0B;
      default: r = ch;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/csed_front.sv
// Front end: accepts characters, tracks the escape state and emits up to two result entries.
`default_nettype none
module csed_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [7:0]     char_byte,
  input  wire logic           string_end,
  output csed_pkg::push_t     push,
  output csed_pkg::mode_t     mode
);
  import csed_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [8:0] acc_r, acc_nxt;
  logic [1:0] dr_r, dr_nxt;

  logic       is_bs, is_x, oct_dig, hex_dig, dr_nz;
  logic [4:0] hv;
  logic [8:0] acc_oct, acc_hex;
  entry_t     ent_char, ent_sum, ent_acc, ent_oct, ent_hex;

  assign is_bs   = (char_byte == CH_BACKSLASH);
  assign is_x    = (char_byte == CH_X);
  assign oct_dig = (char_byte >= CH_ZERO) && (char_byte <= CH_SEVEN);
  assign hv      = hex_value(char_byte);
  assign hex_dig = hv[4];
  assign dr_nz   = (dr_r != 2'd0);
  assign acc_oct = {acc_r[5:0], char_byte[2:0]};
  assign acc_hex = {acc_r[4:0], hv[3:0]};

  assign ent_char = '{data: char_byte, summary: 1'b0, last: 1'b0};
  assign ent_sum  = '{data: 8'd0, summary: 1'b1, last: 1'b0};
  assign ent_acc  = '{data: acc_r[7:0], summary: 1'b0, last: 1'b0};
  assign ent_oct  = '{data: acc_oct[7:0], summary: 1'b0, last: 1'b0};
  assign ent_hex  = '{data: acc_hex[7:0], summary: 1'b0, last: 1'b0};

  // Next state.
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dr_nxt   = dr_r;
    if (string_end) begin
      mode_nxt = MODE_NORMAL;
      acc_nxt  = 9'd0;
      dr_nxt   = 2'd0;
    end else begin
      unique case (mode_r)
        MODE_NORMAL: begin
          if (is_bs) mode_nxt = MODE_ESCAPE;
        end
        MODE_ESCAPE: begin
          if (oct_dig) begin
            mode_nxt = MODE_OCTAL;
            acc_nxt  = {6'd0, char_byte[2:0]};
            dr_nxt   = ESC_DIGITS;
          end else if (is_x) begin
            mode_nxt = MODE_HEX;
            acc_nxt  = 9'd0;
            dr_nxt   = ESC_DIGITS;
          end else begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_OCTAL, MODE_HEX: begin
          if ((mode_r == MODE_OCTAL ? oct_dig : hex_dig) && dr_nz) begin
            if (dr_r == 2'd1) begin
              mode_nxt = MODE_NORMAL;
              acc_nxt  = 9'd0;
              dr_nxt   = 2'd0;
            end else begin
              acc_nxt = (mode_r == MODE_OCTAL) ? acc_oct : acc_hex;
              dr_nxt  = dr_r - 2'd1;
            end
          end else begin
            // The pending value is flushed and the character is handled as plain input.
            mode_nxt = is_bs ? MODE_ESCAPE : MODE_NORMAL;
            acc_nxt  = 9'd0;
            dr_nxt   = 2'd0;
          end
        end
        default: mode_nxt = MODE_NORMAL;
      endcase
    end
  end

  // Result entries.
  always_comb begin
    push = '0;
    if (string_end) begin
      unique case (mode_r)
        MODE_ESCAPE: begin
          push.v0 = 1'b1;
          push.e0 = '{data: 8'd0, summary: 1'b0, last: 1'b0};
          push.v1 = 1'b1;
          push.e1 = ent_sum;
        end
        MODE_OCTAL, MODE_HEX: begin
          push.v0 = 1'b1;
          push.e0 = ent_acc;
          push.v1 = 1'b1;
          push.e1 = ent_sum;
        end
        default: begin
          push.v0 = 1'b1;
          push.e0 = ent_sum;
        end
      endcase
    end else begin
      unique case (mode_r)
        MODE_NORMAL: begin
          push.v0 = !is_bs;
          push.e0 = ent_char;
        end
        MODE_ESCAPE: begin
          push.v0 = !oct_dig && !is_x;
          push.e0 = '{data: map_escape(char_byte), summary: 1'b0, last: 1'b0};
        end
        MODE_OCTAL, MODE_HEX: begin
          if ((mode_r == MODE_OCTAL ? oct_dig : hex_dig) && dr_nz) begin
            push.v0 = (dr_r == 2'd1);
            push.e0 = (mode_r == MODE_OCTAL) ? ent_oct : ent_hex;
          end else begin
            push.v0 = 1'b1;
            push.e0 = ent_acc;
            push.v1 = !is_bs;
            push.e1 = ent_char;
          end
        end
        default: push = '0;
      endcase
    end
    push.e0.last = !push.v1;
    push.e1.last = 1'b1;
    push.v0      = push.v0 & accept;
    push.v1      = push.v1 & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= 9'd0;
      dr_r   <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dr_r   <= dr_nxt;
    end
  end

  assign mode = mode_r;

endmodule
`default_nettype wire

### src/csed_queue.sv
// Result queue: takes up to two entries per cycle from the front end, gives one per cycle when popped.
`default_nettype none
module csed_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire csed_pkg::push_t  push,
  input  wire logic             pop,
  output csed_pkg::entry_t      head,
  output csed_pkg::qstat_t      stat
);
  import csed_pkg::*;

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, wr_p1;
  logic [QLVL_W-1:0]   level_r, level_nxt;

  assign wr_p1      = wr_ptr_r + QPTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.v0) + QPTR_W'(push.v1);
  assign level_nxt  = level_r + QLVL_W'(push.v0) + QLVL_W'(push.v1) - QLVL_W'(pop);

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_ptr_r] <= push.e0;
    if (push.v1) mem_r[wr_p1]    <= push.e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      level_r  <= level_nxt;
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (level_r == '0);
  assign stat.room  = (level_r <= QLVL_W'(QDEPTH - 2));
  assign stat.level = level_r;

endmodule
`default_nettype wire

### src/csed_back.sv
// Back end: counts decoded bytes and holds the result in the output register.
`default_nettype none
module csed_back #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire csed_pkg::entry_t head,
  input  wire csed_pkg::qstat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_decoded_byte,
  output logic [15:0]           out_length_so_far,
  output logic                  out_is_summary,
  output logic                  out_last_of_run
);
  import csed_pkg::*;

  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt, cnt_inc, cnt_rep;
  logic [32:0]            cnt_ext;
  logic                   vld_r;
  logic [7:0]             byte_r;
  logic [15:0]            len_r, len_nxt;
  logic                   sum_r, last_r;

  assign pop     = !stat.empty && (!vld_r || out_ready);
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + LENGTH_BITS'(1);
  assign cnt_rep = head.summary ? cnt_r : cnt_inc;
  assign cnt_nxt = head.summary ? '0 : cnt_inc;
  assign cnt_ext = 33'(cnt_rep);
  // The reported length is capped at 16 bits for counter widths up to 33 bits.
  assign len_nxt = (|cnt_ext[32:16]) ? 16'hFFFF : cnt_ext[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (pop) begin
        vld_r <= 1'b1;
        cnt_r <= cnt_nxt;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r <= head.data;
      len_r  <= len_nxt;
      sum_r  <= head.summary;
      last_r <= head.last;
    end
  end

  assign out_valid         = vld_r;
  assign out_decoded_byte  = byte_r;
  assign out_length_so_far = len_r;
  assign out_is_summary    = sum_r;
  assign out_last_of_run   = last_r;

endmodule
`default_nettype wire

### src/c_string_escape_decoder.sv
// Streaming C string escape decoder: one source character per cycle in while the result
// queue has room, decoded bytes out. A result passes through the result queue and then the
// output register; a character that yields two results puts both into the four-entry
// result queue between front and back end, which hands them on one at a time.
// Reset (rst_n low, synchronous) returns to normal mode, clears the length count and
// empties the queue and output register.
`default_nettype none
module c_string_escape_decoder #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_string_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_decoded_byte,
  output logic [15:0]      out_length_so_far,
  output logic             out_is_summary,
  output logic             out_last_of_run
);
  import csed_pkg::*;

  logic   accept;
  logic   pop;
  push_t  push;
  entry_t head;
  qstat_t stat;
  mode_t  mode;

  assign in_ready = stat.room;
  assign accept   = in_valid && in_ready;

  csed_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .char_byte  (in_char_byte),
    .string_end (in_string_end),
    .push       (push),
    .mode       (mode)
  );

  csed_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  csed_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .stat              (stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decoded_byte  (out_decoded_byte),
    .out_length_so_far (out_length_so_far),
    .out_is_summary    (out_is_summary),
    .out_last_of_run   (out_last_of_run)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= QLVL_W'(QDEPTH))
    else $error("result queue level exceeds its depth");

  a_end_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_string_end |=> mode == MODE_NORMAL)
    else $error("end of string did not return the decoder to normal mode");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_summary |-> out_decoded_byte == 8'd0 && out_last_of_run)
    else $error("summary result carries a byte or is not last of its run");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("result queue popped while empty");
`endif

endmodule
`default_nettype wire

### verif/csed_checker.sv
`timescale 1ns / 1ps
// Checker for the escape decoder: decodes accepted requests itself and compares every result.
module csed_checker #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_string_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_decoded_byte,
  input  logic [15:0] out_length_so_far,
  input  logic        out_is_summary,
  input  logic        out_last_of_run,
  output int          mismatches,
  output int          pending_results
);
  import csed_pkg::*;

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [7:0]  dbyte;
    logic [15:0] length;
    logic        summary;
    logic        last;
  } decoded_t;

  mode_t                  mode_r;
  logic [8:0]             accum_r;
  logic [1:0]             digits_left_r;
  logic [LENGTH_BITS-1:0] byte_count_r;
  decoded_t               expected_bytes[$];

  function automatic logic [7:0] control_code(input logic [7:0] ch);
    case (ch)
      "a":     return 8'h07;
      "b":     return 8'h08;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "t":     return 8'h09;
      "v":     return 8'h0B;
      default: return ch;
    endcase
  endfunction

  function automatic logic hex_digit(input logic [7:0] ch, output logic [3:0] val);
    val = '0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      val = ch[3:0];
      return 1'b1;
    end
    if ((ch >= CH_UPPER_A && ch <= CH_UPPER_F) || (ch >= CH_LOWER_A && ch <= CH_LOWER_F)) begin
      // Letters a-f and A-F share the low three bits: 1..6 maps to 10..15.
      val = 4'd9 + {1'b0, ch[2:0]};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic restart_string();
    mode_r        = MODE_NORMAL;
    accum_r       = '0;
    digits_left_r = '0;
    byte_count_r  = '0;
  endtask

  task automatic emit(input logic [7:0] value, input logic summary);
    decoded_t d;
    if (!summary && byte_count_r != COUNT_MAX) byte_count_r++;
    d.dbyte   = value;
    d.length  = (64'(byte_count_r) > 64'hFFFF) ? 16'hFFFF : 16'(byte_count_r);
    d.summary = summary;
    d.last    = 1'b0;
    expected_bytes.push_back(d);
  endtask

  task automatic close_escape();
    emit(accum_r[7:0], 1'b0);
    mode_r        = MODE_NORMAL;
    accum_r       = '0;
    digits_left_r = '0;
  endtask

  task automatic take_plain(input logic [7:0] ch);
    if (ch == CH_BACKSLASH) begin
      mode_r = MODE_ESCAPE;
    end else begin
      emit(ch, 1'b0);
    end
  endtask

  task automatic decode_request(input logic [7:0] ch, input logic eos);
    logic [3:0] hval;
    logic       is_hex;
    int         prior_size;
    decoded_t   tail;
    prior_size = expected_bytes.size();
    if (eos) begin
      // A lone backslash before the end yields a zero byte.
      if (mode_r == MODE_ESCAPE) begin
        accum_r = '0;
        close_escape();
      end else if (mode_r != MODE_NORMAL) begin
        close_escape();
      end
      emit(8'h00, 1'b1);
      restart_string();
    end else begin
      case (mode_r)
        MODE_NORMAL: take_plain(ch);
        MODE_ESCAPE: begin
          if (ch >= CH_ZERO && ch <= CH_SEVEN) begin
            mode_r        = MODE_OCTAL;
            accum_r       = {6'd0, ch[2:0]};
            digits_left_r = ESC_DIGITS;
          end else if (ch == CH_X) begin
            mode_r        = MODE_HEX;
            accum_r       = '0;
            digits_left_r = ESC_DIGITS;
          end else begin
            mode_r = MODE_NORMAL;
            emit(control_code(ch), 1'b0);
          end
        end
        MODE_OCTAL: begin
          if (ch >= CH_ZERO && ch <= CH_SEVEN && digits_left_r != 0) begin
            accum_r = {accum_r[5:0], ch[2:0]};
            digits_left_r--;
            if (digits_left_r == 0) close_escape();
          end else begin
            close_escape();
            take_plain(ch);
          end
        end
        default: begin
          is_hex = hex_digit(ch, hval);
          if (is_hex && digits_left_r != 0) begin
            accum_r = {accum_r[4:0], hval};
            digits_left_r--;
            if (digits_left_r == 0) close_escape();
          end else begin
            close_escape();
            take_plain(ch);
          end
        end
      endcase
    end
    if (expected_bytes.size() > prior_size) begin
      tail      = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endtask

  task automatic report_field(input string name, input logic [15:0] want, input logic [15:0] got);
    $error("%s: expected %0h, got %0h", name, want, got);
  endtask

  task automatic check_result();
    decoded_t want;
    logic     bad;
    if (expected_bytes.size() == 0) begin
      $error("result with none expected: decoded_byte %0h, length_so_far %0h",
             out_decoded_byte, out_length_so_far);
      mismatches++;
    end else begin
      want = expected_bytes.pop_front();
      bad  = 1'b0;
      if (out_decoded_byte !== want.dbyte) begin
        bad = 1'b1;
        report_field("decoded_byte", 16'(want.dbyte), 16'(out_decoded_byte));
      end
      if (out_length_so_far !== want.length) begin
        bad = 1'b1;
        report_field("length_so_far", want.length, out_length_so_far);
      end
      if (out_is_summary !== want.summary) begin
        bad = 1'b1;
        report_field("is_summary", 16'(want.summary), 16'(out_is_summary));
      end
      if (out_last_of_run !== want.last) begin
        bad = 1'b1;
        report_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
      end
      if (bad) mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_string();
      expected_bytes.delete();
      mismatches = 0;
    end else begin
      // A result never belongs to a request accepted at the same edge, so pop first.
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) decode_request(in_char_byte, in_string_end);
    end
    pending_results <= expected_bytes.size();
  end

endmodule

### verif/tb_c_string_escape_decoder.sv
`timescale 1ns / 1ps
// Testbench top for the C string escape decoder: character stimulus, result sink and verdict.
module tb_c_string_escape_decoder;
  import csed_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_CHARS = 1300;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 14;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [7:0] CTRL_LETTERS [7] = '{"a", "b", "f", "n", "r", "t", "v"};

  typedef struct packed {
    logic       eos;
    logic [7:0] ch;
  } src_char_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [7:0]  in_char_byte  = 8'h00;
  logic        in_string_end = 1'b0;
  logic        out_ready     = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_decoded_byte;
  logic [15:0] out_length_so_far;
  logic        out_is_summary;
  logic        out_last_of_run;

  logic        src_idle_en  = 1'b1;
  logic        sink_idle_en = 1'b1;
  logic        sink_hold    = 1'b0;
  int          cycle_cnt    = 0;
  int          chars_sent   = 0;
  int          mismatches;
  int          pending_results;
  src_char_t   source_text[$];

  c_string_escape_decoder #(.LENGTH_BITS(16)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_byte      (in_char_byte),
    .in_string_end     (in_string_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decoded_byte  (out_decoded_byte),
    .out_length_so_far (out_length_so_far),
    .out_is_summary    (out_is_summary),
    .out_last_of_run   (out_last_of_run)
  );

  csed_checker #(.LENGTH_BITS(16)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_byte      (in_char_byte),
    .in_string_end     (in_string_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decoded_byte  (out_decoded_byte),
    .out_length_so_far (out_length_so_far),
    .out_is_summary    (out_is_summary),
    .out_last_of_run   (out_last_of_run),
    .mismatches        (mismatches),
    .pending_results   (pending_results)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Result sink: random stalls, plus one long hold-off so the block backs up into its input.
  initial begin : sink
    logic held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (sink_hold && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= sink_idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic queue_char(input logic [7:0] ch);
    source_text.push_back({1'b0, ch});
  endtask

  task automatic queue_end();
    // The character field is meaningless on the end request, so it carries noise.
    source_text.push_back({1'b1, 8'($urandom_range(255))});
  endtask

  task automatic send_char(input src_char_t c);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_byte  <= c.ch;
    in_string_end <= c.eos;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic flush_source();
    while (source_text.size() != 0) begin
      send_char(source_text.pop_front());
      chars_sent++;
    end
  endtask

  // Plain characters and escapes with random content, with some noise and string ends mixed in.
  task automatic queue_random_piece();
    int         pick;
    int         n;
    logic [7:0] ch;
    logic [3:0] v;
    pick = $urandom_range(99);
    if (pick < 38) begin
      ch = 8'($urandom_range(255));
      queue_char((ch == CH_BACKSLASH) ? (ch ^ 8'h80) : ch);
    end else if (pick < 50) begin
      queue_char(CH_BACKSLASH);
      queue_char(CTRL_LETTERS[$urandom_range(6)]);
    end else if (pick < 66) begin
      queue_char(CH_BACKSLASH);
      n = $urandom_range(1, 3);
      repeat (n) queue_char(CH_ZERO + 8'($urandom_range(7)));
    end else if (pick < 82) begin
      queue_char(CH_BACKSLASH);
      queue_char(CH_X);
      n = $urandom_range(0, 2);
      repeat (n) begin
        v = 4'($urandom_range(15));
        if (v < 4'd10) begin
          queue_char(CH_ZERO + 8'(v));
        end else begin
          queue_char(($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10);
        end
      end
    end else if (pick < 90) begin
      queue_char(CH_BACKSLASH);
      queue_char($urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(255)));
    end else if (pick < 96) begin
      queue_char(8'($urandom_range(255)));
    end else begin
      queue_end();
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes, every control escape, octal truncation, an 8 ending an octal escape.
    queue_char(8'h00);
    queue_char(8'hFF);
    foreach (CTRL_LETTERS[i]) begin
      queue_char(CH_BACKSLASH);
      queue_char(CTRL_LETTERS[i]);
    end
    queue_char(CH_BACKSLASH);
    repeat (3) queue_char(CH_SEVEN);
    queue_char(CH_BACKSLASH);
    queue_char("1");
    queue_char("8");
    queue_end();
    // Hex escape without digits, a hex value flushed by the end, then a trailing backslash.
    queue_char(CH_BACKSLASH);
    queue_char(CH_X);
    queue_char("g");
    queue_char(CH_BACKSLASH);
    queue_char(CH_X);
    queue_char("4");
    queue_end();
    queue_char(CH_BACKSLASH);
    queue_end();
    flush_source();

    while (chars_sent < RANDOM_CHARS) begin
      // A stretch with no idling on either side, then the long hold-off.
      src_idle_en  = !(chars_sent >= 450 && chars_sent < 800);
      sink_idle_en = src_idle_en;
      if (chars_sent >= 900) sink_hold = 1'b1;
      queue_random_piece();
      flush_source();
    end
    queue_end();
    flush_source();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
